// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the digest cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define ASSERT_NO_RST(lbl, clk_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);
`else
`define ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`define ASSERT_NO_RST(lbl, clk_i, prop, msg)
`endif

`endif

// ----- hdl/dmdc_pkg.sv -----
// Shared types and constants of the digest cache.
`timescale 1ns / 1ps

package dmdc_pkg;

  localparam int SLOTS_DEF         = 4096;
  localparam int SLOT_COUNT_W      = 13;
  localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST = 13'd4096;
  localparam int KEY_W             = 64;
  localparam int KEY_WORDS         = 4;
  localparam int TAG_W             = KEY_W * KEY_WORDS;
  localparam int HASH_W            = 16;
  localparam int REM_BITS_PER_STEP = 4;
  localparam int REM_STEPS         = HASH_W / REM_BITS_PER_STEP;
  localparam int REM_STEP_W        = $clog2(REM_STEPS);
  localparam int FUNC_W            = 2;
  localparam int CNT_W             = 32;
  localparam int OUT_W             = 72;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } entry_t;

endpackage

// ----- hdl/dmdc_urem.sv -----
// Iterative remainder of the 16-bit slot hash by the slot count, four bits a cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmdc_urem (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [dmdc_pkg::HASH_W-1:0]          dividend,
  input  logic [dmdc_pkg::SLOT_COUNT_W-1:0]    divisor,
  output logic                                 done,
  output logic [dmdc_pkg::SLOT_COUNT_W-1:0]    remainder
);

  localparam int RW = dmdc_pkg::SLOT_COUNT_W;
  localparam int BS = dmdc_pkg::REM_BITS_PER_STEP;
  localparam int HW = dmdc_pkg::HASH_W;

  logic                             busy_r;
  logic                             done_r;
  logic [dmdc_pkg::REM_STEP_W-1:0]  step_r;
  logic [HW-1:0]                    quot_r;
  logic [RW-1:0]                    rem_r;
  logic [RW-1:0]                    div_r;
  logic [RW-1:0]                    rem_nxt;

  always_comb begin
    logic [RW:0]   t;
    logic [RW-1:0] v;
    v = rem_r;
    for (int k = 0; k < BS; k++) begin
      t = {v, quot_r[HW-1-k]};
      if (t >= {1'b0, div_r}) begin
        v = RW'(t - {1'b0, div_r});
      end else begin
        v = t[RW-1:0];
      end
    end
    rem_nxt = v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        step_r <= '0;
        quot_r <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        quot_r <= quot_r << BS;
        rem_r  <= rem_nxt;
        step_r <= step_r + 1'b1;
        if (step_r == dmdc_pkg::REM_STEP_W'(dmdc_pkg::REM_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          done_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

  `ASSERT_CLK(a_start_when_free, clk, rst_n, start |-> !busy_r, "remainder unit restarted while busy")

endmodule

// ----- hdl/direct_mapped_digest_cache.sv -----
// Top level of the direct-mapped digest presence cache.
//
// Input channel in_*: one beat per operation. in_tuser carries the function
// (lookup, insert, clear), in_tdata the 256-bit digest as four 64-bit words.
// Output channel out_*: one beat per operation with hit, evicted and the two
// saturating totals after the operation.
// cfg_wr_en/cfg_wr_data write the slot count (0 disables the cache); write
// only while no operation is in flight.
// A lookup or insert passes from accept to out_tvalid through the remainder
// unit that maps the hash onto the slot count, the hand-over of the slot, the
// tag memory read, the compare/write state and the output register. One
// operation is in flight at a time, so the block takes no new beat until the
// last one has left its final stage. A clear zeroes the counters and sweeps
// the valid bits, one slot per cycle, before its result beat. After reset
// the same sweep runs over every slot with in_tready low and no result beat.
// A stalled receiver holds the result in the output register; the next beat
// is accepted meanwhile and waits in its final stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module direct_mapped_digest_cache #(
  parameter int SLOTS = dmdc_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dmdc_pkg::TAG_W-1:0]          in_tdata,    // key_word0, key_word1, key_word2, key_word3
  input  logic [dmdc_pkg::FUNC_W-1:0]         in_tuser,    // func
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dmdc_pkg::OUT_W-1:0]          out_tdata,   // hit, evicted, hit_total, eviction_total
  input  logic                                cfg_wr_en,
  input  logic [dmdc_pkg::SLOT_COUNT_W-1:0]   cfg_wr_data  // slot_count
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW     = dmdc_pkg::CNT_W;
  localparam int NW     = dmdc_pkg::SLOT_COUNT_W;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_DIV,
    S_READ,
    S_CMP,
    S_FIN
  } state_t;

  state_t                  state_r;
  logic [SLOT_W-1:0]       sweep_idx_r;
  logic                    sweep_rsp_r;
  dmdc_pkg::func_t         func_r;
  logic [dmdc_pkg::TAG_W-1:0] key_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [CW-1:0]           hit_cnt_r;
  logic [CW-1:0]           evict_cnt_r;
  logic                    res_hit_r;
  logic                    res_evict_r;
  logic                    out_tvalid_r;
  logic [dmdc_pkg::OUT_W-1:0] out_tdata_r;
  logic [NW-1:0]           slot_count_r;
  dmdc_pkg::entry_t        rd_entry_r;

  dmdc_pkg::entry_t        mem [SLOTS];

  logic                    in_acc;
  logic [NW-1:0]           n_eff;
  logic                    div_start;
  logic                    div_done;
  logic [NW-1:0]           div_rem;
  logic                    tag_match;
  logic                    mem_we;
  logic [SLOT_W-1:0]       mem_addr;
  dmdc_pkg::entry_t        mem_wdata;
  dmdc_pkg::func_t         in_func;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_func   = dmdc_pkg::func_t'(in_tuser);

  always_comb begin
    if (32'(slot_count_r) > 32'(SLOTS)) begin
      n_eff = NW'(SLOTS);
    end else begin
      n_eff = slot_count_r;
    end
  end

  assign div_start = in_acc && (n_eff != '0) &&
                     (in_func == dmdc_pkg::FUNC_LOOKUP || in_func == dmdc_pkg::FUNC_INSERT);

  dmdc_urem u_urem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_tdata[dmdc_pkg::HASH_W-1:0]),
    .divisor   (n_eff),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign tag_match = rd_entry_r.valid && (rd_entry_r.tag == key_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = slot_r;
    mem_wdata = '{valid: 1'b1, tag: key_r};
    if (state_r == S_SWEEP) begin
      mem_we    = 1'b1;
      mem_addr  = sweep_idx_r;
      mem_wdata = '0;
    end else if (state_r == S_CMP && func_r == dmdc_pkg::FUNC_INSERT) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_entry_r <= mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      sweep_idx_r  <= '0;
      sweep_rsp_r  <= 1'b0;
      hit_cnt_r    <= '0;
      evict_cnt_r  <= '0;
      out_tvalid_r <= 1'b0;
      slot_count_r <= dmdc_pkg::SLOT_COUNT_RST;
    end else begin
      if (cfg_wr_en) begin
        slot_count_r <= cfg_wr_data;
      end
      if (out_tvalid_r && out_tready && state_r != S_FIN) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_SWEEP: begin
          if (sweep_idx_r == SLOT_W'(SLOTS - 1)) begin
            sweep_idx_r <= '0;
            state_r     <= sweep_rsp_r ? S_FIN : S_IDLE;
          end else begin
            sweep_idx_r <= sweep_idx_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            func_r      <= in_func;
            key_r       <= in_tdata;
            res_hit_r   <= 1'b0;
            res_evict_r <= 1'b0;
            if (in_func == dmdc_pkg::FUNC_CLEAR) begin
              hit_cnt_r   <= '0;
              evict_cnt_r <= '0;
              sweep_idx_r <= '0;
              sweep_rsp_r <= 1'b1;
              state_r     <= S_SWEEP;
            end else if (div_start) begin
              state_r <= S_DIV;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            slot_r  <= SLOT_W'(div_rem);
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (func_r == dmdc_pkg::FUNC_LOOKUP) begin
            res_hit_r <= tag_match;
            if (tag_match && hit_cnt_r != '1) begin
              hit_cnt_r <= hit_cnt_r + 1'b1;
            end
          end else begin
            res_evict_r <= rd_entry_r.valid && !tag_match;
            if (rd_entry_r.valid && !tag_match && evict_cnt_r != '1) begin
              evict_cnt_r <= evict_cnt_r + 1'b1;
            end
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {6'b0, evict_cnt_r, hit_cnt_r, res_evict_r, res_hit_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `ASSERT_CLK(a_one_in_flight, clk, rst_n, in_acc |=> !in_tready, "second beat accepted while busy")
  `ASSERT_CLK(a_div_done_in_div, clk, rst_n, div_done |-> (state_r == S_DIV), "stray remainder result")
  `ASSERT_CLK(a_tag_write_insert, clk, rst_n, (mem_we && mem_wdata.valid) |-> (state_r == S_CMP && func_r == dmdc_pkg::FUNC_INSERT), "valid entry written outside insert")
  `ASSERT_CLK(a_hit_cnt_change, clk, rst_n, ($past(rst_n) && hit_cnt_r != $past(hit_cnt_r)) |-> ($past(state_r) == S_CMP || $past(in_acc)), "hit counter moved without an operation")

endmodule

// ----- verif/direct_mapped_digest_cache_check.sv -----
// Checker for the digest cache: predicts every operation and compares each result beat.
`timescale 1ns / 1ps

module direct_mapped_digest_cache_check #(
  parameter int SLOTS = dmdc_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [dmdc_pkg::TAG_W-1:0]        in_tdata,
  input  logic [dmdc_pkg::FUNC_W-1:0]       in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [dmdc_pkg::OUT_W-1:0]        out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [dmdc_pkg::SLOT_COUNT_W-1:0] cfg_wr_data,
  output int                                fail_count,
  output int                                pending_count,
  output int                                hits_seen,
  output int                                evictions_seen
);

  typedef struct packed {
    logic                       hit;
    logic                       evicted;
    logic [dmdc_pkg::CNT_W-1:0] hit_total;
    logic [dmdc_pkg::CNT_W-1:0] eviction_total;
  } cache_result_t;

  logic [dmdc_pkg::SLOT_COUNT_W-1:0] slot_count_q;
  logic                              slot_valid [SLOTS];
  logic [dmdc_pkg::TAG_W-1:0]        slot_tag [SLOTS];
  logic [dmdc_pkg::CNT_W-1:0]        hit_cnt;
  logic [dmdc_pkg::CNT_W-1:0]        evict_cnt;
  cache_result_t                     expected_results [$];
  cache_result_t                     want;
  cache_result_t                     got;
  int                                mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [dmdc_pkg::CNT_W-1:0] sat_bump(
      input logic [dmdc_pkg::CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic cache_result_t predict_lookup_insert(
      input logic [dmdc_pkg::FUNC_W-1:0] func,
      input logic [dmdc_pkg::TAG_W-1:0] key);
    cache_result_t r;
    int n;
    int s;
    r = '0;
    n = (slot_count_q > SLOTS) ? SLOTS : int'(slot_count_q);
    if (func == dmdc_pkg::FUNC_CLEAR) begin
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      hit_cnt = '0;
      evict_cnt = '0;
    end else if ((func == dmdc_pkg::FUNC_LOOKUP || func == dmdc_pkg::FUNC_INSERT) && n != 0) begin
      s = int'(key[15:0]) % n;
      if (func == dmdc_pkg::FUNC_LOOKUP) begin
        if (slot_valid[s] && slot_tag[s] == key) begin
          r.hit = 1'b1;
          hit_cnt = sat_bump(hit_cnt);
        end
      end else begin
        if (slot_valid[s] && slot_tag[s] != key) begin
          r.evicted = 1'b1;
          evict_cnt = sat_bump(evict_cnt);
        end
        slot_tag[s] = key;
        slot_valid[s] = 1'b1;
      end
    end
    r.hit_total = hit_cnt;
    r.eviction_total = evict_cnt;
    return r;
  endfunction

  task automatic report_field(input string name, input logic [dmdc_pkg::CNT_W-1:0] exp_v,
                              input logic [dmdc_pkg::CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      slot_count_q = dmdc_pkg::SLOT_COUNT_RST;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      hit_cnt = '0;
      evict_cnt = '0;
      expected_results.delete();
      pending_count <= 0;
      hits_seen <= 0;
      evictions_seen <= 0;
    end else begin
      if (cfg_wr_en) slot_count_q = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        got.hit            = out_tdata[0];
        got.evicted        = out_tdata[1];
        got.hit_total      = out_tdata[33:2];
        got.eviction_total = out_tdata[65:34];
        if (expected_results.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          report_field("hit", dmdc_pkg::CNT_W'(want.hit), dmdc_pkg::CNT_W'(got.hit));
          report_field("evicted", dmdc_pkg::CNT_W'(want.evicted),
                       dmdc_pkg::CNT_W'(got.evicted));
          report_field("hit_total", want.hit_total, got.hit_total);
          report_field("eviction_total", want.eviction_total, got.eviction_total);
          if (want.hit) hits_seen <= hits_seen + 1;
          if (want.evicted) evictions_seen <= evictions_seen + 1;
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_lookup_insert(in_tuser, in_tdata));
      pending_count <= expected_results.size();
    end
  end

endmodule

// ----- verif/direct_mapped_digest_cache_test.sv -----
// Testbench top for the digest cache: clock, reset, stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module direct_mapped_digest_cache_test;

  localparam logic [dmdc_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [dmdc_pkg::TAG_W-1:0]        in_tdata;
  logic [dmdc_pkg::FUNC_W-1:0]       in_tuser;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [dmdc_pkg::OUT_W-1:0]        out_tdata;
  logic                              cfg_wr_en;
  logic [dmdc_pkg::SLOT_COUNT_W-1:0] cfg_wr_data;

  int fail_count;
  int pending_count;
  int hits_seen;
  int evictions_seen;

  bit quiet_mode;
  int stall_left;
  int lookups_sent;
  int inserts_sent;
  int clears_sent;
  int unused_sent;
  int settings_used;
  logic [dmdc_pkg::TAG_W-1:0] key_pool [$];

  direct_mapped_digest_cache dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  direct_mapped_digest_cache_check chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .hits_seen      (hits_seen),
    .evictions_seen (evictions_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("direct_mapped_digest_cache regression: fail");
    $finish;
  end

  function automatic int idle_len();
    int roll;
    if (quiet_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [dmdc_pkg::TAG_W-1:0] rand_digest();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Receiver: random stalls on the result channel.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left <= idle_len();
    end
  end

  task automatic send_op(input logic [dmdc_pkg::FUNC_W-1:0] func,
                         input logic [dmdc_pkg::TAG_W-1:0] digest);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= rand_digest();
      in_tuser <= dmdc_pkg::FUNC_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= digest;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (func)
      dmdc_pkg::FUNC_LOOKUP: lookups_sent++;
      dmdc_pkg::FUNC_INSERT: begin
        inserts_sent++;
        key_pool.push_back(digest);
        if (key_pool.size() > 24) void'(key_pool.pop_front());
      end
      dmdc_pkg::FUNC_CLEAR: clears_sent++;
      default: unused_sent++;
    endcase
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0 || !in_tready) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_slot_count(input logic [dmdc_pkg::SLOT_COUNT_W-1:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [dmdc_pkg::TAG_W-1:0] pick_digest();
    logic [dmdc_pkg::TAG_W-1:0] d;
    int roll;
    int idx;
    roll = $urandom_range(0, 99);
    if (key_pool.size() != 0 && roll < 75) begin
      idx = $urandom_range(0, key_pool.size() - 1);
      if (roll < 50) return key_pool[idx];
      d = key_pool[idx];
      if (roll < 62) begin
        d[$urandom_range(16, dmdc_pkg::TAG_W - 1)] ^= 1'b1;
      end else begin
        d = rand_digest();
        d[15:0] = key_pool[idx][15:0];
      end
      return d;
    end
    d = rand_digest();
    if ($urandom_range(0, 1) == 0) d[15:0] = 16'($urandom_range(0, 31));
    return d;
  endfunction

  initial begin
    logic [dmdc_pkg::TAG_W-1:0] zero_key;
    logic [dmdc_pkg::TAG_W-1:0] ones_key;
    logic [dmdc_pkg::TAG_W-1:0] same_slot_key;
    logic [dmdc_pkg::TAG_W-1:0] top_bit_key;
    logic [dmdc_pkg::SLOT_COUNT_W-1:0] phase_slots [9];
    logic [dmdc_pkg::FUNC_W-1:0] func;
    int roll;

    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= dmdc_pkg::FUNC_LOOKUP;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    quiet_mode = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    zero_key = '0;
    ones_key = '1;
    same_slot_key = rand_digest();
    same_slot_key[15:0] = 16'h0FFF;
    top_bit_key = ones_key;
    top_bit_key[dmdc_pkg::TAG_W-1] = 1'b0;

    send_op(dmdc_pkg::FUNC_LOOKUP, zero_key);
    send_op(dmdc_pkg::FUNC_INSERT, zero_key);
    send_op(dmdc_pkg::FUNC_LOOKUP, zero_key);
    send_op(dmdc_pkg::FUNC_INSERT, ones_key);
    send_op(dmdc_pkg::FUNC_LOOKUP, ones_key);
    send_op(dmdc_pkg::FUNC_LOOKUP, top_bit_key);
    send_op(dmdc_pkg::FUNC_INSERT, same_slot_key);
    send_op(dmdc_pkg::FUNC_LOOKUP, ones_key);
    send_op(dmdc_pkg::FUNC_LOOKUP, same_slot_key);
    send_op(dmdc_pkg::FUNC_INSERT, same_slot_key);
    send_op(FUNC_UNUSED, same_slot_key);
    send_op(FUNC_UNUSED, ones_key);
    send_op(dmdc_pkg::FUNC_CLEAR, zero_key);
    send_op(dmdc_pkg::FUNC_LOOKUP, same_slot_key);

    write_slot_count(13'd0);
    send_op(dmdc_pkg::FUNC_INSERT, zero_key);
    send_op(dmdc_pkg::FUNC_LOOKUP, zero_key);
    write_slot_count(13'd1);
    send_op(dmdc_pkg::FUNC_INSERT, ones_key);
    send_op(dmdc_pkg::FUNC_INSERT, same_slot_key);
    send_op(dmdc_pkg::FUNC_LOOKUP, same_slot_key);
    send_op(dmdc_pkg::FUNC_LOOKUP, zero_key);
    write_slot_count(13'd8191);
    send_op(dmdc_pkg::FUNC_INSERT, ones_key);
    send_op(dmdc_pkg::FUNC_LOOKUP, ones_key);

    phase_slots[0] = 13'd4096;
    phase_slots[1] = 13'd1;
    phase_slots[2] = 13'd0;
    phase_slots[3] = 13'd8191;
    phase_slots[4] = 13'd7;
    phase_slots[5] = 13'd4097;
    phase_slots[6] = 13'd4095;
    phase_slots[7] = 13'($urandom_range(2, 300));
    phase_slots[8] = 13'($urandom_range(0, 8191));

    for (int phase = 0; phase < 9; phase++) begin
      write_slot_count(phase_slots[phase]);
      quiet_mode = (phase % 3 == 1);
      for (int i = 0; i < 60; i++) begin
        if (phase == 4 && i == 30) drain_results();
        roll = $urandom_range(0, 199);
        if (roll < 3) func = dmdc_pkg::FUNC_CLEAR;
        else if (roll < 9) func = FUNC_UNUSED;
        else if (roll < 100) func = dmdc_pkg::FUNC_LOOKUP;
        else func = dmdc_pkg::FUNC_INSERT;
        send_op(func, pick_digest());
      end
    end
    quiet_mode = 1'b0;

    drain_results();
    repeat (20) @(posedge clk);

    $display("covered %0d lookups (%0d hits), %0d inserts (%0d evictions), %0d clears, %0d unused",
             lookups_sent, hits_seen, inserts_sent, evictions_seen, clears_sent, unused_sent);
    $display("over %0d slot counts: disabled, one slot, small, full size and above it",
             settings_used);
    if (fail_count == 0 && pending_count == 0) begin
      $display("direct_mapped_digest_cache regression: pass");
    end else begin
      $display("direct_mapped_digest_cache regression: fail");
    end
    $finish;
  end

endmodule
